// File: hdl/sae64_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Small-scale AES-64 package
// Types, constant tables and round functions shared by the pipeline stages.
// Nibble i of a 64-bit word sits in bits 63-4i down to 60-4i.
// ----------------------------------------------------------------------------
package sae64_pkg;

  localparam int unsigned BLOCK_W    = 64;
  localparam int unsigned NIB_COUNT  = 16;
  localparam int unsigned NUM_ROUNDS = 10;

  // Forward S-box of the 4-bit cipher.
  localparam logic [3:0] SBOX_TABLE [0:15] = '{
    4'h6, 4'hb, 4'h5, 4'h4, 4'h2, 4'he, 4'h7, 4'ha,
    4'h9, 4'hd, 4'hf, 4'hc, 4'h3, 4'h1, 4'h0, 4'h8
  };

  // Multiplication by x and by x+1 in GF(2^4) modulo x^4+x+1.
  localparam logic [3:0] GMUL2_TABLE [0:15] = '{
    4'h0, 4'h2, 4'h4, 4'h6, 4'h8, 4'ha, 4'hc, 4'he,
    4'h3, 4'h1, 4'h7, 4'h5, 4'hb, 4'h9, 4'hf, 4'hd
  };
  localparam logic [3:0] GMUL3_TABLE [0:15] = '{
    4'h0, 4'h3, 4'h6, 4'h5, 4'hc, 4'hf, 4'ha, 4'h9,
    4'hb, 4'h8, 4'hd, 4'he, 4'h7, 4'h4, 4'h1, 4'h2
  };

  // Round constants, the powers of x.
  localparam logic [3:0] RCON_TABLE [0:10] = '{
    4'h1, 4'h2, 4'h4, 4'h8, 4'h3, 4'h6, 4'hc, 4'hb, 4'h5, 4'ha, 4'h7
  };

  // Payload that moves from stage to stage: cipher state and round key.
  typedef struct packed {
    logic [BLOCK_W-1:0] state;
    logic [BLOCK_W-1:0] rkey;
  } pipe_t;

  // Substitute every nibble through the S-box.
  function automatic logic [BLOCK_W-1:0] sub_nibbles(input logic [BLOCK_W-1:0] s);
    logic [BLOCK_W-1:0] t;
    t = '0;
    for (int i = 0; i < NIB_COUNT; i++) begin
      t[BLOCK_W-1-4*i -: 4] = SBOX_TABLE[s[BLOCK_W-1-4*i -: 4]];
    end
    return t;
  endfunction

  // Row r of each column moves left by r columns.
  function automatic logic [BLOCK_W-1:0] shift_rows(input logic [BLOCK_W-1:0] s);
    logic [BLOCK_W-1:0] t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[BLOCK_W-1-4*(c*4+r) -: 4] = s[BLOCK_W-1-4*((((c+r) % 4)*4)+r) -: 4];
      end
    end
    return t;
  endfunction

  // Column mixing with the circulant matrix (2 3 1 1).
  function automatic logic [BLOCK_W-1:0] mix_columns(input logic [BLOCK_W-1:0] s);
    logic [BLOCK_W-1:0] t;
    logic [3:0] a0, a1, a2, a3;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = s[BLOCK_W-1-4*(c*4)   -: 4];
      a1 = s[BLOCK_W-1-4*(c*4+1) -: 4];
      a2 = s[BLOCK_W-1-4*(c*4+2) -: 4];
      a3 = s[BLOCK_W-1-4*(c*4+3) -: 4];
      t[BLOCK_W-1-4*(c*4)   -: 4] = GMUL2_TABLE[a0] ^ GMUL3_TABLE[a1] ^ a2 ^ a3;
      t[BLOCK_W-1-4*(c*4+1) -: 4] = a0 ^ GMUL2_TABLE[a1] ^ GMUL3_TABLE[a2] ^ a3;
      t[BLOCK_W-1-4*(c*4+2) -: 4] = a0 ^ a1 ^ GMUL2_TABLE[a2] ^ GMUL3_TABLE[a3];
      t[BLOCK_W-1-4*(c*4+3) -: 4] = GMUL3_TABLE[a0] ^ a1 ^ a2 ^ GMUL2_TABLE[a3];
    end
    return t;
  endfunction

  // One step of the key schedule: previous round key to the next one.
  function automatic logic [BLOCK_W-1:0] key_step(input logic [BLOCK_W-1:0] rk,
                                                  input logic [3:0] rc);
    logic [15:0] w3, g, n0, n1, n2, n3;
    w3 = rk[15:0];
    g  = {SBOX_TABLE[w3[11:8]] ^ rc, SBOX_TABLE[w3[7:4]],
          SBOX_TABLE[w3[3:0]], SBOX_TABLE[w3[15:12]]};
    n0 = rk[63:48] ^ g;
    n1 = rk[47:32] ^ n0;
    n2 = rk[31:16] ^ n1;
    n3 = rk[15:0]  ^ n2;
    return {n0, n1, n2, n3};
  endfunction

endpackage

// File: hdl/sae64_round_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Round stage
// One cipher round and one key schedule step, followed by a stage register
// with its own valid bit. The stage loads whenever it is empty or its
// contents move on in the same cycle.
// ----------------------------------------------------------------------------
module sae64_round_stage #(
  parameter int unsigned RoundIdx = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              up_valid,
  input  sae64_pkg::pipe_t  up_data,
  output logic              up_ready,
  output logic              dn_valid,
  output sae64_pkg::pipe_t  dn_data,
  input  logic              dn_ready
);
  import sae64_pkg::*;

  localparam logic [3:0] RoundConst = RCON_TABLE[RoundIdx-1];
  localparam bit         LastRound  = (RoundIdx == NUM_ROUNDS);

  logic [BLOCK_W-1:0] rkey_next;
  logic [BLOCK_W-1:0] shifted;
  logic [BLOCK_W-1:0] mixed;
  pipe_t              data_next;
  logic               valid;
  pipe_t              data;

  // Next round key runs beside the substitution and mixing logic.
  always_comb begin
    rkey_next = key_step(up_data.rkey, RoundConst);
    shifted   = shift_rows(sub_nibbles(up_data.state));
    mixed     = LastRound ? shifted : mix_columns(shifted);
    data_next.state = mixed ^ rkey_next;
    data_next.rkey  = rkey_next;
  end

  // The stage can take a new item when empty or when its item leaves.
  assign up_ready = !valid || dn_ready;

  // Stage register with valid bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data <= data_next;
    end
  end

  assign dn_valid = valid;
  assign dn_data  = data;

endmodule

// File: hdl/small_aes64_nibble_encrypt_core.sv
`timescale 1ns / 1ps
// A plaintext transfer passes from the key addition register through each round stage register to ciphertext_valid.
// Throughput: one block per cycle while ciphertext_stall is low; eleven register stages (key addition, ten rounds).
// Each round stage computes its round key from the one carried with the block.
// Reset (rst, synchronous) empties all stages and clears the key to zero.
// ----------------------------------------------------------------------------
// Small-scale AES-64 encrypt core
// Pipelined encryptor for a 64-bit block with 4-bit S-boxes. The key is a
// static register; the key schedule travels down the pipeline with the data.
// ----------------------------------------------------------------------------
module small_aes64_nibble_encrypt_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cipher_key_we,
  input  logic [63:0] cipher_key_wdata,
  input  logic        plaintext_valid,
  output logic        plaintext_stall,
  input  logic [63:0] plaintext,
  output logic        ciphertext_valid,
  input  logic        ciphertext_stall,
  output logic [63:0] ciphertext
);
  import sae64_pkg::*;

  logic [BLOCK_W-1:0] cipher_key;
  logic               stage_valid [0:NUM_ROUNDS];
  pipe_t              stage_data  [0:NUM_ROUNDS];
  logic               stage_take  [0:NUM_ROUNDS];

  // Key register; the user must write it only while the pipeline is empty, as the block itself has no check for this.
  always_ff @(posedge clk) begin
    if (rst) begin
      cipher_key <= '0;
    end else if (cipher_key_we) begin
      cipher_key <= cipher_key_wdata;
    end
  end

  // Input stage: initial key addition.
  assign stage_take[0]   = !stage_valid[0] || stage_take[1];
  assign plaintext_stall = !stage_take[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid[0] <= 1'b0;
    end else if (stage_take[0]) begin
      stage_valid[0] <= plaintext_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_take[0] && plaintext_valid) begin
      stage_data[0].state <= plaintext ^ cipher_key;
      stage_data[0].rkey  <= cipher_key;
    end
  end

  // Round stages.
  for (genvar k = 1; k <= NUM_ROUNDS; k++) begin : g_round
    logic down_ready;
    if (k == NUM_ROUNDS) begin : g_last
      assign down_ready = !ciphertext_stall;
    end else begin : g_mid
      assign down_ready = stage_take[k+1];
    end

    sae64_round_stage #(
      .RoundIdx (k)
    ) u_stage (
      .clk      (clk),
      .rst      (rst),
      .up_valid (stage_valid[k-1]),
      .up_data  (stage_data[k-1]),
      .up_ready (stage_take[k]),
      .dn_valid (stage_valid[k]),
      .dn_data  (stage_data[k]),
      .dn_ready (down_ready)
    );
  end

  // Output transfer comes straight from the last stage register.
  assign ciphertext_valid = stage_valid[NUM_ROUNDS];
  assign ciphertext       = stage_data[NUM_ROUNDS].state;

endmodule

// File: hdl/sae64_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Port checker
// Watches the core's ports for reset, back pressure and output hold rules.
// ----------------------------------------------------------------------------
module sae64_checker (
  input logic        clk,
  input logic        rst,
  input logic        plaintext_stall,
  input logic        ciphertext_valid,
  input logic        ciphertext_stall,
  input logic [63:0] ciphertext
);

  // A reset empties the whole pipeline.
  a_reset_empties: assert property (@(posedge clk)
    $past(rst) |-> !ciphertext_valid)
    else $error("ciphertext_valid high right after reset");

  // The input is held back only when the output side blocks a full pipeline.
  a_stall_cause: assert property (@(posedge clk)
    plaintext_stall |-> (ciphertext_valid && ciphertext_stall))
    else $error("input stalled while the output is free");

  // An open output never pushes back on the input.
  a_flow_through: assert property (@(posedge clk)
    !ciphertext_stall |-> !plaintext_stall)
    else $error("input stalled although the output is taking transfers");

  // A stalled result stays and does not change.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (ciphertext_valid && ciphertext_stall) |=> (ciphertext_valid && $stable(ciphertext)))
    else $error("stalled ciphertext dropped or changed");

endmodule

bind small_aes64_nibble_encrypt_core sae64_checker u_sae64_checker (
  .clk              (clk),
  .rst              (rst),
  .plaintext_stall  (plaintext_stall),
  .ciphertext_valid (ciphertext_valid),
  .ciphertext_stall (ciphertext_stall),
  .ciphertext       (ciphertext)
);
